// ===== sv/wtsc_pkg.sv =====
// Package: shared types and constants for the waypoint-to-steer block.
package wtsc_pkg;

   localparam int CordicSteps = 17;
   localparam logic signed [19:0] HalfPi = 20'sd102944;
   localparam logic signed [19:0] Pi = 20'sd205887;
   localparam logic signed [19:0] TwoPi = 20'sd411775;
   localparam logic signed [17:0] SpeedBump = 18'sd205;
   localparam logic signed [17:0] SpeedFloor = 18'sd1024;
   localparam logic signed [17:0] SpeedMax = 18'sd65535;
   localparam logic [27:0] DistFloor = 28'd102;
   localparam logic [19:0] FinalTime = 20'd51;
   localparam logic [19:0] TimeMax = 20'd1048575;

   localparam logic OP_CAR = 1'b0;
   localparam logic OP_POSE = 1'b1;

   typedef struct packed {
      logic        operation;
      logic [39:0] pos_x;
      logic [39:0] pos_y;
      logic [15:0] heading;
      logic [16:0] speed;
      logic        last_pose;
   } req_type;

   typedef struct packed {
      logic [19:0] step_time;
      logic [16:0] cmd_speed;
      logic [15:0] steer_angle;
      logic [39:0] target_x;
      logic [39:0] target_y;
      logic [15:0] target_heading;
      logic        last_cmd;
   } rsp_type;

   // arctangent of 2^-i in 2^-16 rad
   function automatic logic [15:0] atan_entry(input logic [4:0] i);
      logic [15:0] r;
      case (i)
         5'd0: r = 16'd51472;
         5'd1: r = 16'd30386;
         5'd2: r = 16'd16055;
         5'd3: r = 16'd8150;
         5'd4: r = 16'd4091;
         5'd5: r = 16'd2047;
         5'd6: r = 16'd1024;
         5'd7: r = 16'd512;
         5'd8: r = 16'd256;
         5'd9: r = 16'd128;
         5'd10: r = 16'd64;
         5'd11: r = 16'd32;
         5'd12: r = 16'd16;
         5'd13: r = 16'd8;
         5'd14: r = 16'd4;
         5'd15: r = 16'd2;
         5'd16: r = 16'd1;
         default: r = 16'd0;
      endcase
      return r;
   endfunction

endpackage

// ===== sv/wtsc_if.sv =====
// Interface: valid/ready channel carrying one payload.
interface wtsc_if #(parameter type payload_type = logic) (input logic clock);
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== sv/waypoint_to_steer_command_top.sv =====
// Top level: waypoint stream to motion commands.
// Usage:
//   req channel carries car-state items (operation 0) and waypoints (operation 1).
//   rsp channel carries up to two commands per waypoint, the final one marked
//   by last_cmd. Car-state items give no command.
// Sequence: a waypoint that releases a held command runs the square root
//   (28 steps) and the 38-step divider with its load cycle in one shared subtract
//   unit, while two 17-step CORDIC passes (bearing, then steer) run in one shared
//   rotation unit. A far waypoint skips the divider. A waypoint that only ends a
//   message offers its command without using either unit.
// Throughput: one item at a time; req_ready is low while an item is in work
//   or a command waits.
// Reset: clears the car state, the pose counter and the held waypoint.
// Stall: a command waits in the output register until rsp_ready; no item is
//   accepted in the meantime.
module waypoint_to_steer_command_top #(
   parameter int SKIP_POSES = 5,
   parameter int MAX_POSES = 20
) (
   input  logic clock,
   input  logic reset,
   wtsc_if.sink   req,
   wtsc_if.source rsp
);
   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_DECIDE = 4'd1;
   localparam logic [3:0] ST_BWAIT = 4'd3;
   localparam logic [3:0] ST_STEER = 4'd4;
   localparam logic [3:0] ST_SWAIT = 4'd5;
   localparam logic [3:0] ST_TWAIT = 4'd6;
   localparam logic [3:0] ST_OUT1 = 4'd7;
   localparam logic [3:0] ST_FINAL = 4'd8;
   localparam logic [3:0] ST_OUT2 = 4'd9;

   logic [3:0] state_ff, state_in;
   wtsc_pkg::req_type item_ff, item_in;
   wtsc_pkg::rsp_type out_ff, out_in;
   logic signed [39:0] car_x_ff, car_x_in, car_y_ff, car_y_in;
   logic signed [15:0] car_h_ff, car_h_in;
   logic signed [16:0] car_v_ff, car_v_in;
   logic [4:0] cnt_ff, cnt_in;
   logic signed [39:0] held_x_ff, held_x_in, held_y_ff, held_y_in;
   logic signed [15:0] held_h_ff, held_h_in;
   logic signed [16:0] held_v_ff, held_v_in;
   logic held_ok_ff, held_ok_in;
   logic signed [19:0] bear_ff, bear_in;
   logic signed [16:0] v_ff, v_in;
   logic far_in;
   logic tdone_ff, tdone_in;
   logic [19:0] time_ff, time_in;

   logic cord_start, cord_done, div_start, div_done;
   logic signed [41:0] cx, cy;
   logic signed [19:0] cord_z;
   logic [19:0] div_q;
   logic [55:0] rad;
   logic signed [40:0] dxs, dys, bx, by;
   logic signed [27:0] adx, ady;
   logic signed [19:0] braw;
   logic signed [22:0] b7;
   logic signed [16:0] vsel;
   logic signed [17:0] vt;
   logic in_window, final_pose;

   assign req.ready = (state_ff == ST_IDLE);
   assign rsp.valid = (state_ff == ST_OUT1) || (state_ff == ST_OUT2);
   assign rsp.data = out_ff;

   // speed rule on the pose speed held in vsel
   always_comb begin
      vt = (18'(car_v_ff) < 18'(vsel)) ? 18'(car_v_ff) + wtsc_pkg::SpeedBump : 18'(vsel);
      if (vt <= wtsc_pkg::SpeedFloor) vt = wtsc_pkg::SpeedFloor;
      if (vt > wtsc_pkg::SpeedMax) vt = wtsc_pkg::SpeedMax;
   end

   assign dxs = 41'(signed'(item_ff.pos_x)) - 41'(held_x_ff);
   assign dys = 41'(signed'(item_ff.pos_y)) - 41'(held_y_ff);
   assign far_in = (dxs >= 41'sd134217728) || (dxs <= -41'sd134217728) ||
                   (dys >= 41'sd134217728) || (dys <= -41'sd134217728);
   assign adx = dxs[27:0];
   assign ady = dys[27:0];
   assign rad = 56'(adx * adx) + 56'(ady * ady);
   assign bx = 41'(held_x_ff) - 41'(car_x_ff);
   assign by = 41'(held_y_ff) - 41'(car_y_ff);
   assign in_window = (32'(cnt_ff) >= SKIP_POSES) && (32'(cnt_ff) < MAX_POSES);
   assign final_pose = item_ff.last_pose || (32'(cnt_ff) == MAX_POSES - 1);

   // bearing wrap and steer argument
   always_comb begin
      braw = cord_z - 20'(signed'({car_h_ff, 3'd0}));
      if (braw > wtsc_pkg::Pi) braw = braw - wtsc_pkg::TwoPi;
      else if (braw < -wtsc_pkg::Pi) braw = braw + wtsc_pkg::TwoPi;
      if (bx == 0 && by == 0) braw = '0;
      b7 = 23'(bear_ff) * 23'sd7;
   end

   // sequencer
   always_comb begin
      state_in = state_ff; item_in = item_ff; out_in = out_ff;
      car_x_in = car_x_ff; car_y_in = car_y_ff; car_h_in = car_h_ff; car_v_in = car_v_ff;
      cnt_in = cnt_ff; held_x_in = held_x_ff; held_y_in = held_y_ff;
      held_h_in = held_h_ff; held_v_in = held_v_ff; held_ok_in = held_ok_ff;
      bear_in = bear_ff; v_in = v_ff; tdone_in = tdone_ff; time_in = time_ff;
      cord_start = 1'b0; div_start = 1'b0; cx = 42'(bx); cy = 42'(by);
      vsel = held_v_ff;
      if (div_done) begin
         tdone_in = 1'b1; time_in = div_q;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               item_in = req.data;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (item_ff.operation == wtsc_pkg::OP_CAR) begin
               car_x_in = item_ff.pos_x; car_y_in = item_ff.pos_y;
               car_h_in = item_ff.heading; car_v_in = item_ff.speed;
               state_in = ST_IDLE;
            end else if (in_window && held_ok_ff) begin
               v_in = 17'(vt);
               div_start = !far_in;
               tdone_in = far_in; time_in = wtsc_pkg::TimeMax;
               cord_start = 1'b1;
               state_in = ST_BWAIT;
            end else if (in_window) begin
               state_in = ST_FINAL;
            end else begin
               state_in = ST_FINAL;
            end
         end
         ST_BWAIT: begin
            if (cord_done) begin
               bear_in = braw; state_in = ST_STEER;
            end
         end
         ST_STEER: begin
            cx = 42'sd65536; cy = 42'(b7 >>> 3);
            cord_start = 1'b1; state_in = ST_SWAIT;
         end
         ST_SWAIT: begin
            if (cord_done) begin
               out_in.steer_angle = 16'((cord_z + 20'sd4) >>> 3);
               state_in = ST_TWAIT;
            end
         end
         ST_TWAIT: begin
            if (tdone_ff) begin
               out_in.step_time = time_ff; out_in.cmd_speed = v_ff;
               out_in.target_x = held_x_ff; out_in.target_y = held_y_ff;
               out_in.target_heading = held_h_ff; out_in.last_cmd = 1'b0;
               held_ok_in = 1'b0; state_in = ST_OUT1;
            end
         end
         ST_OUT1: begin
            if (rsp.ready) state_in = ST_FINAL;
         end
         ST_FINAL: begin
            state_in = ST_IDLE;
            if (in_window) begin
               if (final_pose) begin
                  vsel = item_ff.speed;
                  out_in.step_time = wtsc_pkg::FinalTime; out_in.cmd_speed = 17'(vt);
                  out_in.steer_angle = '0; out_in.target_x = item_ff.pos_x;
                  out_in.target_y = item_ff.pos_y; out_in.target_heading = item_ff.heading;
                  out_in.last_cmd = 1'b1; state_in = ST_OUT2;
               end else begin
                  held_x_in = item_ff.pos_x; held_y_in = item_ff.pos_y;
                  held_h_in = item_ff.heading; held_v_in = item_ff.speed;
                  held_ok_in = 1'b1;
               end
            end
            if (item_ff.last_pose) begin
               cnt_in = '0; held_ok_in = 1'b0;
            end else if (cnt_ff != 5'd31) begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         ST_OUT2: begin
            if (rsp.ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; car_x_ff <= '0; car_y_ff <= '0; car_h_ff <= '0;
         car_v_ff <= '0; cnt_ff <= '0; held_x_ff <= '0; held_y_ff <= '0;
         held_h_ff <= '0; held_v_ff <= '0; held_ok_ff <= 1'b0; tdone_ff <= 1'b0;
      end else begin
         state_ff <= state_in; car_x_ff <= car_x_in; car_y_ff <= car_y_in;
         car_h_ff <= car_h_in; car_v_ff <= car_v_in; cnt_ff <= cnt_in;
         held_x_ff <= held_x_in; held_y_ff <= held_y_in; held_h_ff <= held_h_in;
         held_v_ff <= held_v_in; held_ok_ff <= held_ok_in;
         tdone_ff <= (state_ff == ST_TWAIT && tdone_ff) ? 1'b0 : tdone_in;
      end
      item_ff <= item_in; out_ff <= out_in; bear_ff <= bear_in; v_ff <= v_in;
      time_ff <= time_in;
   end

   wtsc_cordic u_cordic (
      .clock(clock), .reset(reset), .start(cord_start), .x_in(cx), .y_in(cy),
      .done(cord_done), .angle(cord_z)
   );

   wtsc_sqdiv u_sqdiv (
      .clock(clock), .reset(reset), .start(div_start), .radicand(rad),
      .divisor(v_in), .done(div_done), .quotient(div_q)
   );

   // checks
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req.ready) else $error("ready while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> rsp.valid) else $error("response dropped");
   a_final_steer: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && out_ff.last_cmd) |-> (out_ff.steer_angle == '0))
      else $error("final command steer not zero");
   a_cnt_reset: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINAL && item_ff.last_pose) |=> (cnt_ff == '0))
      else $error("pose count not cleared");
endmodule

// ===== sv/wtsc_cordic.sv =====
// Module: iterative vectoring CORDIC, one micro-rotation per cycle.
module wtsc_cordic (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [41:0] x_in,
   input  logic signed [41:0] y_in,
   output logic               done,
   output logic signed [19:0] angle
);
   logic signed [44:0] x_ff, x_in_n, y_ff, y_in_n;
   logic signed [19:0] z_ff, z_in;
   logic [4:0]         step_ff, step_in;
   logic               busy_ff, busy_in, done_ff, done_in;
   logic signed [44:0] xs, ys;

   assign xs = x_ff >>> step_ff;
   assign ys = y_ff >>> step_ff;

   // quadrant pre-rotation at start, then one step per cycle
   always_comb begin
      x_in_n = x_ff; y_in_n = y_ff; z_in = z_ff;
      step_in = step_ff; busy_in = busy_ff; done_in = 1'b0;
      if (start) begin
         step_in = 5'd0; busy_in = 1'b1;
         if (x_in < 0) begin
            if (y_in >= 0) begin
               x_in_n = 45'(y_in); y_in_n = -45'(x_in); z_in = wtsc_pkg::HalfPi;
            end else begin
               x_in_n = -45'(y_in); y_in_n = 45'(x_in); z_in = -wtsc_pkg::HalfPi;
            end
         end else begin
            x_in_n = 45'(x_in); y_in_n = 45'(y_in); z_in = '0;
         end
      end else if (busy_ff) begin
         if (y_ff > 0) begin
            x_in_n = x_ff + ys; y_in_n = y_ff - xs;
            z_in = z_ff + 20'(signed'({1'b0, wtsc_pkg::atan_entry(step_ff)}));
         end else begin
            x_in_n = x_ff - ys; y_in_n = y_ff + xs;
            z_in = z_ff - 20'(signed'({1'b0, wtsc_pkg::atan_entry(step_ff)}));
         end
         step_in = step_ff + 5'd1;
         if (step_ff == 5'(wtsc_pkg::CordicSteps - 1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
      x_ff <= x_in_n; y_ff <= y_in_n; z_ff <= z_in; step_ff <= step_in;
   end

   assign done = done_ff;
   assign angle = z_ff;
endmodule

// ===== sv/wtsc_sqdiv.sv =====
// Module: bit-serial square root and restoring divider sharing one subtractor.
module wtsc_sqdiv (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [55:0] radicand,
   input  logic [16:0] divisor,
   output logic        done,
   output logic [19:0] quotient
);
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SQRT = 2'd1;
   localparam logic [1:0] S_DIV = 2'd2;

   logic [1:0]  state_ff, state_in;
   logic [55:0] n_ff, n_in;
   logic [55:0] res_ff, res_in;
   logic [55:0] bit_ff, bit_in;
   logic [38:0] rem_ff, rem_in;
   logic [37:0] num_ff, num_in;
   logic [19:0] q_ff, q_in;
   logic        sat_ff, sat_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [16:0] dv_ff, dv_in;
   logic        done_ff, done_in;
   logic [56:0] sub_a, sub_b, diff;
   logic [27:0] d;
   logic [38:0] rsh;

   assign rsh = {rem_ff[37:0], num_ff[37]};

   // shared subtractor
   always_comb begin
      if (state_ff == S_SQRT) begin
         sub_a = {1'b0, n_ff}; sub_b = {1'b0, res_ff + bit_ff};
      end else begin
         sub_a = 57'(rsh); sub_b = 57'(dv_ff);
      end
      diff = sub_a - sub_b;
   end

   always_comb begin
      state_in = state_ff; n_in = n_ff; res_in = res_ff; bit_in = bit_ff;
      rem_in = rem_ff; num_in = num_ff; q_in = q_ff; sat_in = sat_ff;
      cnt_in = cnt_ff; dv_in = dv_ff; done_in = 1'b0;
      d = (res_ff[27:0] > wtsc_pkg::DistFloor) ? res_ff[27:0] : wtsc_pkg::DistFloor;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               n_in = radicand; res_in = '0; bit_in = 56'd1 << 54;
               dv_in = divisor; state_in = S_SQRT;
            end
         end
         S_SQRT: begin
            if (!diff[56]) begin
               n_in = diff[55:0]; res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff[0]) begin
               state_in = S_DIV; rem_in = '0; q_in = '0; sat_in = 1'b0;
               cnt_in = 6'd38;
               num_in = '0;
            end
         end
         S_DIV: begin
            if (cnt_ff == 6'd38) begin
               num_in = {d, 10'd0};
               cnt_in = 6'd37;
            end else begin
               if (!diff[56]) begin
                  rem_in = diff[38:0];
               end else begin
                  rem_in = rsh;
               end
               num_in = {num_ff[36:0], 1'b0};
               if (q_ff[19]) sat_in = 1'b1;
               q_in = {q_ff[18:0], ~diff[56]};
               if (cnt_ff == 6'd0) begin
                  state_in = S_IDLE; done_in = 1'b1;
               end else begin
                  cnt_in = cnt_ff - 6'd1;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; done_ff <= 1'b0;
      end else begin
         state_ff <= state_in; done_ff <= done_in;
      end
      n_ff <= n_in; res_ff <= res_in; bit_ff <= bit_in; rem_ff <= rem_in;
      num_ff <= num_in; q_ff <= q_in; sat_ff <= sat_in; cnt_ff <= cnt_in;
      dv_ff <= dv_in;
   end

   assign done = done_ff;
   assign quotient = sat_ff ? wtsc_pkg::TimeMax : q_ff;
endmodule
